/* rtl/esc2d_pkg.sv */
// ----------------------------------------------------------------------------
// esc2d_pkg: shared types and constants of the epoch-to-date converter
// Widths, calendar constants, the sequencer states and the month length table.
// ----------------------------------------------------------------------------
package esc2d_pkg;

  // Number of seconds bits taken from the input beat (32 to 64).
  localparam int EPOCH_WIDTH = 32;

  localparam int SECS_PER_DAY  = 86400;
  localparam int DAYS_PER_400Y = 146097;
  localparam int YEAR_BASE     = 1970;
  localparam int YEAR_LIMIT    = 4095;

  // 86400 > 2**16, so the day count needs 16 bits fewer than the seconds.
  localparam int DAYS_W  = EPOCH_WIDTH - 16;
  // Remainders stay below 146097 < 2**18; a trial dividend holds one more bit.
  localparam int REM_W   = 18;
  localparam int TRIAL_W = REM_W + 1;
  localparam int CNT_W   = $clog2(EPOCH_WIDTH);
  // The working year holds 1970 + 400 * cycles + 399 at any width.
  localparam int YEAR_W  = DAYS_W;

  // Position of 1970 in the 400-year and 100-year leap pattern.
  localparam int BASE_MOD400 = YEAR_BASE % 400;
  localparam int BASE_MOD100 = YEAR_BASE % 100;

  localparam logic [11:0] SAT_YEAR  = 12'(YEAR_LIMIT);
  localparam logic [3:0]  SAT_MONTH = 4'd12;
  localparam logic [4:0]  SAT_DAY   = 5'd31;
  localparam logic [3:0]  LAST_MONTH = 4'd11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_DAY,
    ST_DIV_CYCLE,
    ST_YEAR,
    ST_MONTH
  } esc2d_state_t;

  // Length of a month, month index from 0, February lengthened in leap years.
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic is_leap);
    logic [4:0] len;
    begin
      case (month)
        4'd1:                       len = is_leap ? 5'd29 : 5'd28;
        4'd3, 4'd5, 4'd8, 4'd10:    len = 5'd30;
        default:                    len = 5'd31;
      endcase
      return len;
    end
  endfunction

endpackage

/* rtl/epoch_seconds_to_calendar_date.sv */
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_date: Unix seconds to Gregorian year, month, day
// A small sequencer drives one shared subtract-and-compare unit through two
// restoring divisions, a year-by-year count and a month-by-month count.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  input    | in_valid, in_stall, in_epoch_seconds    | into block
//  result   | out_valid, out_stall, out_year,         | out of block
//           | out_month, out_day                      |
//
// One beat runs through the two divisions, a count of whole years plus a final
// compare, a count of whole months plus a final compare (skipped when the year
// passes 4095 and the result saturates), and a return to idle before the next
// beat is taken; the shared subtractor serves these steps one after another.
// in_stall is high while a beat is in work. A finished result sits in the
// output register until taken; the block accepts the next beat meanwhile but
// holds its own result until the register frees up. Reset clears the
// sequencer and out_valid.
module epoch_seconds_to_calendar_date
  import esc2d_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [EPOCH_WIDTH-1:0] in_epoch_seconds,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [11:0]            out_year,
  output logic [3:0]             out_month,
  output logic [4:0]             out_day
);

  esc2d_state_t state_r, state_nxt;

  logic [EPOCH_WIDTH-1:0] num_r, num_nxt;
  logic [REM_W-1:0]       rem_r, rem_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [YEAR_W-1:0]      acc_r, acc_nxt;
  logic [YEAR_W-1:0]      year_r, year_nxt;
  logic [8:0]             mod400_r, mod400_nxt;
  logic [6:0]             mod100_r, mod100_nxt;
  logic [3:0]             month_r, month_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [11:0] out_year_r, out_year_nxt;
  logic [3:0]  out_month_r, out_month_nxt;
  logic [4:0]  out_day_r, out_day_nxt;

  // Shared subtract-and-compare unit.
  logic [TRIAL_W-1:0] sub_a, sub_b;
  logic [TRIAL_W:0]   sub_diff;
  logic               sub_ge;

  logic       is_leap;
  logic [4:0] mlen;
  logic       accept;
  logic       out_free;
  logic       month_done;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign is_leap  = (mod400_r[1:0] == 2'd0 && mod100_r != 7'd0) || (mod400_r == 9'd0);
  assign mlen     = month_len(month_r, is_leap);

  always_comb begin
    sub_a = {1'b0, rem_r};
    sub_b = '0;
    unique case (state_r)
      ST_DIV_DAY: begin
        sub_a = {rem_r, num_r[EPOCH_WIDTH-1]};
        sub_b = TRIAL_W'(SECS_PER_DAY);
      end
      ST_DIV_CYCLE: begin
        sub_a = {rem_r, num_r[EPOCH_WIDTH-1]};
        sub_b = TRIAL_W'(DAYS_PER_400Y);
      end
      ST_YEAR:  sub_b = is_leap ? TRIAL_W'(366) : TRIAL_W'(365);
      ST_MONTH: sub_b = {{(TRIAL_W-5){1'b0}}, mlen};
      default:  sub_b = '0;
    endcase
  end

  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = !sub_diff[TRIAL_W];

  // The month count ends on a short remainder or on December.
  assign month_done = !sub_ge || (month_r == LAST_MONTH);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (accept) state_nxt = ST_DIV_DAY;
      ST_DIV_DAY:   if (cnt_r == '0) state_nxt = ST_DIV_CYCLE;
      ST_DIV_CYCLE: if (cnt_r == '0) state_nxt = ST_YEAR;
      ST_YEAR: begin
        if (!sub_ge) begin
          if (year_r > YEAR_W'(YEAR_LIMIT)) begin
            if (out_free) state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_MONTH;
          end
        end
      end
      ST_MONTH:     if (month_done && out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    year_nxt      = year_r;
    mod400_nxt    = mod400_r;
    mod100_nxt    = mod100_r;
    month_nxt     = month_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_year_nxt  = out_year_r;
    out_month_nxt = out_month_r;
    out_day_nxt   = out_day_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          num_nxt    = in_epoch_seconds;
          rem_nxt    = '0;
          cnt_nxt    = CNT_W'(EPOCH_WIDTH - 1);
          acc_nxt    = '0;
          mod400_nxt = 9'(BASE_MOD400);
          mod100_nxt = 7'(BASE_MOD100);
          month_nxt  = '0;
        end
      end
      ST_DIV_DAY: begin
        rem_nxt = sub_ge ? sub_diff[REM_W-1:0] : sub_a[REM_W-1:0];
        num_nxt = {num_r[EPOCH_WIDTH-2:0], sub_ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          // The day count sits in the low bits; bring its top bit to the front.
          num_nxt = {num_r[EPOCH_WIDTH-2:0], sub_ge} << (EPOCH_WIDTH - DAYS_W);
          rem_nxt = '0;
          cnt_nxt = CNT_W'(DAYS_W - 1);
        end
      end
      ST_DIV_CYCLE: begin
        rem_nxt = sub_ge ? sub_diff[REM_W-1:0] : sub_a[REM_W-1:0];
        num_nxt = {num_r[EPOCH_WIDTH-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        // Quotient bits arrive MSB first, so 400 * quotient builds by doubling.
        acc_nxt = {acc_r[YEAR_W-2:0], 1'b0} + (sub_ge ? YEAR_W'(400) : YEAR_W'(0));
        if (cnt_r == '0) year_nxt = acc_nxt + YEAR_W'(YEAR_BASE);
      end
      ST_YEAR: begin
        if (sub_ge) begin
          rem_nxt    = sub_diff[REM_W-1:0];
          year_nxt   = year_r + 1'b1;
          mod400_nxt = (mod400_r == 9'd399) ? 9'd0 : mod400_r + 1'b1;
          mod100_nxt = (mod100_r == 7'd99) ? 7'd0 : mod100_r + 1'b1;
        end else if (year_r > YEAR_W'(YEAR_LIMIT) && out_free) begin
          out_valid_nxt = 1'b1;
          out_year_nxt  = SAT_YEAR;
          out_month_nxt = SAT_MONTH;
          out_day_nxt   = SAT_DAY;
        end
      end
      ST_MONTH: begin
        if (!month_done) begin
          rem_nxt   = sub_diff[REM_W-1:0];
          month_nxt = month_r + 1'b1;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_year_nxt  = year_r[11:0];
          out_month_nxt = month_r + 1'b1;
          out_day_nxt   = rem_r[4:0] + 1'b1;
        end
      end
      default: begin
        num_nxt = num_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r       <= num_nxt;
    rem_r       <= rem_nxt;
    cnt_r       <= cnt_nxt;
    acc_r       <= acc_nxt;
    year_r      <= year_nxt;
    mod400_r    <= mod400_nxt;
    mod100_r    <= mod100_nxt;
    month_r     <= month_nxt;
    out_year_r  <= out_year_nxt;
    out_month_r <= out_month_nxt;
    out_day_r   <= out_day_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_year  = out_year_r;
  assign out_month = out_month_r;
  assign out_day   = out_day_r;

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for epoch_seconds_to_calendar_date
// Feeds a short table of hand-picked instants, then a few hundred random ones
// weighted toward month and year boundaries. Each beat's date comes from the
// table or a behavioral calendar in the bench; results are compared in order.
// Both channels idle at random, with two long receiver hold-offs.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import esc2d_pkg::*;

  localparam int RANDOM_BEATS    = 500;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int DRAIN_CYCLES    = 250;
  localparam longint unsigned DAY_SECS   = 86400;
  localparam longint unsigned CYCLE_DAYS = 146097;
  localparam longint unsigned FIRST_YEAR = 1970;
  localparam longint unsigned TOP_YEAR   = 4095;
  localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  typedef struct {
    logic [31:0] secs;
    bit          typed;
    date_t       want;
  } vector_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [EPOCH_WIDTH-1:0] in_epoch_seconds;
  logic                   out_valid;
  logic                   out_stall;
  logic [11:0]            out_year;
  logic [3:0]             out_month;
  logic [4:0]             out_day;

  date_t pending_dates[$];
  int    mismatches = 0;
  bit    hold_off_req = 1'b0;

  wire in_beat  = in_valid && !in_stall;
  wire out_beat = out_valid && !out_stall;

  epoch_seconds_to_calendar_date DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day          (out_day)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic bit is_leap_year(input longint unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  // Calendar date of an instant, counted the long way: whole 400-year cycles
  // first, then single years, then months; years past 4095 saturate.
  function automatic date_t to_calendar(input logic [EPOCH_WIDTH-1:0] secs);
    longint unsigned days, yr, ylen, mlen;
    int mon;
    date_t d;
    days = 64'(secs) / DAY_SECS;
    yr = FIRST_YEAR + 400 * (days / CYCLE_DAYS);
    days = days % CYCLE_DAYS;
    ylen = is_leap_year(yr) ? 366 : 365;
    while (days >= ylen) begin
      days -= ylen;
      yr++;
      ylen = is_leap_year(yr) ? 366 : 365;
    end
    if (yr > TOP_YEAR) begin
      d.year  = 12'd4095;
      d.month = 4'd12;
      d.day   = 5'd31;
      return d;
    end
    mon = 0;
    while (mon < 12) begin
      mlen = (mon == 1 && is_leap_year(yr)) ? 29 : MONTH_DAYS[mon];
      if (days < mlen) break;
      days -= mlen;
      mon++;
    end
    d.year  = yr[11:0];
    d.month = 4'(mon + 1);
    d.day   = 5'(days + 1);
    return d;
  endfunction

  // Mostly back-to-back or short gaps; a few long ones. Every hundred beats
  // starts with a run of twenty offered back to back.
  function automatic int pick_gap(input int idx);
    int r;
    r = $urandom_range(0, 99);
    if (idx % 100 < 20 || r < 50) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 200);
  endfunction

  task automatic drive_beat(input logic [EPOCH_WIDTH-1:0] secs, input date_t want,
                            input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_epoch_seconds <= secs;
    do @(posedge clk); while (in_stall);
    pending_dates.push_back(want);
    @(negedge clk);
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Result side: compare each beat with the oldest expected date.
  always @(posedge clk) begin : check_results
    date_t want;
    if (rst_n && out_beat) begin
      if (pending_dates.size() == 0) begin
        $display("%0t: unexpected result %0d-%0d-%0d", $time, out_year, out_month, out_day);
        mismatches++;
      end else begin
        want = pending_dates.pop_front();
        if (out_year !== want.year) begin
          $display("%0t: year expected %0d actual %0d", $time, want.year, out_year);
          mismatches++;
        end
        if (out_month !== want.month) begin
          $display("%0t: month expected %0d actual %0d", $time, want.month, out_month);
          mismatches++;
        end
        if (out_day !== want.day) begin
          $display("%0t: day expected %0d actual %0d", $time, want.day, out_day);
          mismatches++;
        end
      end
    end
  end

  // Receiver stall pattern, one stretch at a time.
  initial begin : result_sink
    int r, len;
    logic level;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        level = 1'b1;
        len = HOLD_OFF_CYCLES;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          level = 1'b0;
          len = $urandom_range(100, 400);
        end else if (r < 70) begin
          level = 1'b0;
          len = 1;
        end else if (r < 95) begin
          level = 1'b1;
          len = $urandom_range(1, 4);
        end else begin
          level = 1'b1;
          len = $urandom_range(20, 300);
        end
      end
      out_stall <= level;
      repeat (len) @(negedge clk);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (in_beat || out_beat) quiet = 0;
      else quiet++;
    end
    $display("epoch_seconds_to_calendar_date: mismatch");
    $finish;
  end

  initial begin : stimulus
    vector_t vectors [];
    date_t want;
    logic [EPOCH_WIDTH-1:0] secs;
    longint unsigned day0, s;
    int y, m, pick;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_epoch_seconds = '0;

    vectors = '{
      '{32'd0,          1'b1, '{12'd1970, 4'd1,  5'd1}},
      '{32'd86399,      1'b1, '{12'd1970, 4'd1,  5'd1}},
      '{32'd86400,      1'b1, '{12'd1970, 4'd1,  5'd2}},
      '{32'd2592000,    1'b0, '0},
      '{32'd31535999,   1'b1, '{12'd1970, 4'd12, 5'd31}},
      '{32'd31536000,   1'b1, '{12'd1971, 4'd1,  5'd1}},
      '{32'd68169600,   1'b0, '0},
      '{32'd946684800,  1'b1, '{12'd2000, 4'd1,  5'd1}},
      '{32'd951782400,  1'b0, '0},
      '{32'd978220799,  1'b0, '0},
      '{32'd1000000000, 1'b0, '0},
      '{32'h7FFFFFFF,   1'b1, '{12'd2038, 4'd1,  5'd19}},
      '{32'h80000000,   1'b0, '0},
      '{32'd4107456000, 1'b0, '0},
      '{32'd4107542399, 1'b0, '0},
      '{32'd4107542400, 1'b0, '0},
      '{32'h0000FFFF,   1'b0, '0},
      '{32'hFFFF0000,   1'b0, '0},
      '{32'h55555555,   1'b0, '0},
      '{32'hAAAAAAAA,   1'b0, '0},
      '{32'hFFFFFFFF,   1'b1, '{12'd2106, 4'd2,  5'd7}}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (vectors[i]) begin
      want = vectors[i].typed ? vectors[i].want : to_calendar(vectors[i].secs);
      drive_beat(vectors[i].secs, want, pick_gap(i));
    end
    wait_until_drained();

    hold_off_req = 1'b1;
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i == RANDOM_BEATS / 2) begin
        wait_until_drained();
        hold_off_req = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        secs = $urandom();
      end else if (pick < 85) begin
        // Land on or next to the first day of a random month, or within its first 28 days.
        y = $urandom_range(1970, 2106);
        m = $urandom_range(0, 11);
        day0 = 0;
        for (int k = 1970; k < y; k++) day0 += is_leap_year(k) ? 366 : 365;
        for (int k = 0; k < m; k++) day0 += (k == 1 && is_leap_year(y)) ? 29 : MONTH_DAYS[k];
        case ($urandom_range(0, 3))
          0:       s = day0 * DAY_SECS - 1;
          1:       s = day0 * DAY_SECS;
          2:       s = day0 * DAY_SECS + DAY_SECS - 1;
          default: s = (day0 + $urandom_range(0, 27)) * DAY_SECS + $urandom_range(0, 86399);
        endcase
        if (s > 64'hFFFFFFFF) secs = 32'hFFFFFFFF - $urandom_range(0, 40 * 86400);
        else secs = s[31:0];
      end else if (pick < 92) begin
        secs = $urandom_range(0, 3 * 86400);
      end else begin
        secs = 32'hFFFFFFFF - $urandom_range(0, 3 * 86400);
      end
      drive_beat(secs, to_calendar(secs), pick_gap(i));
    end
    in_valid <= 1'b0;

    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_dates.size() == 0) begin
      $display("epoch_seconds_to_calendar_date: match");
    end else begin
      $display("epoch_seconds_to_calendar_date: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/esc2d_pkg.sv
rtl/epoch_seconds_to_calendar_date.sv
bench/tb.sv
